// ===== rtl/lfcrb_pkg.sv =====
`timescale 1ns / 1ps
// lfcrb_pkg: shared types and constants for the line-framed character ring buffer.
// No dependencies.
package lfcrb_pkg;

    localparam int unsigned LC_W = 7;
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [LC_W-1:0] LINE_COUNT_MAX = 7'd127;

    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } item_t;

endpackage

// ===== rtl/lfcrb_front.sv =====
`timescale 1ns / 1ps
// lfcrb_front: input transaction decode and a two-entry command queue.
// Depends on lfcrb_pkg.
module lfcrb_front
    import lfcrb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       command,
    input  logic [7:0] char_in,
    output logic       q_valid,
    output item_t      q_item,
    input  logic       q_take
);

    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    item_t      slot_reg [2];
    item_t      new_item;
    logic       accept;
    logic       take;

    assign in_stall = (count_reg == 2'd2);
    assign accept   = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign take     = q_valid && q_take;
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.op   = command ? OP_POP : OP_PUSH;
        new_item.data = char_in;
    end

    always_comb
    begin
        case ({accept, take})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                wr_ptr_reg <= !wr_ptr_reg;
            if (take)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            slot_reg[wr_ptr_reg] <= new_item;
    end

endmodule

// ===== rtl/lfcrb_back.sv =====
`timescale 1ns / 1ps
// lfcrb_back: ring storage, push/pop execution and the output register.
// Depends on lfcrb_pkg.
module lfcrb_back
    import lfcrb_pkg::*;
#(
    parameter int unsigned DEPTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  item_t      q_item,
    output logic       q_take,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] char_out,
    output logic       last
);

    localparam int unsigned PW = $clog2(DEPTH);

    typedef enum logic [1:0] {
        B_IDLE,
        B_PRIME,
        B_STREAM
    } state_t;

    state_t          state_reg, state_next;
    logic [PW-1:0]   write_pos_reg, write_pos_next;
    logic [PW-1:0]   read_pos_reg, read_pos_next;
    logic [PW-1:0]   cnt_reg, cnt_next;
    logic [LC_W-1:0] line_count_reg, line_count_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      char_out_reg, char_out_next;
    logic            last_reg, last_next;
    logic [7:0]      rdata_reg;
    logic [7:0]      ring_mem [DEPTH];
    logic            do_write;
    logic            load_ok;
    logic            is_nl;

    function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
        next_pos = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign q_take    = (state_reg == B_IDLE);
    assign load_ok   = !out_valid_reg || !out_stall;
    assign is_nl     = (rdata_reg == NEWLINE_BYTE);
    assign out_valid = out_valid_reg;
    assign char_out  = char_out_reg;
    assign last      = last_reg;

    always_comb
    begin
        state_next      = state_reg;
        write_pos_next  = write_pos_reg;
        read_pos_next   = read_pos_reg;
        cnt_next        = cnt_reg;
        line_count_next = line_count_reg;
        out_valid_next  = out_valid_reg && out_stall;
        char_out_next   = char_out_reg;
        last_next       = last_reg;
        do_write        = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.op == OP_PUSH)
                    begin
                        if (!(line_count_reg != '0 && write_pos_reg == read_pos_reg))
                        begin
                            do_write       = 1'b1;
                            write_pos_next = next_pos(write_pos_reg);
                            if (q_item.data == NEWLINE_BYTE &&
                                line_count_reg != LINE_COUNT_MAX)
                                line_count_next = line_count_reg + LC_W'(1);
                        end
                    end
                    else if (line_count_reg != '0)
                    begin
                        state_next = B_PRIME;
                        cnt_next   = '0;
                    end
                end
            end
            B_PRIME:
                state_next = B_STREAM;
            B_STREAM:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    char_out_next  = rdata_reg;
                    last_next      = is_nl;
                    read_pos_next  = next_pos(read_pos_reg);
                    cnt_next       = cnt_reg + PW'(1);
                    if (is_nl || cnt_reg == PW'(DEPTH - 1))
                    begin
                        line_count_next = line_count_reg - LC_W'(1);
                        state_next      = B_IDLE;
                    end
                end
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            write_pos_reg  <= '0;
            read_pos_reg   <= '0;
            cnt_reg        <= '0;
            line_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            char_out_reg   <= 8'd0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            write_pos_reg  <= write_pos_next;
            read_pos_reg   <= read_pos_next;
            cnt_reg        <= cnt_next;
            line_count_reg <= line_count_next;
            out_valid_reg  <= out_valid_next;
            char_out_reg   <= char_out_next;
            last_reg       <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
            ring_mem[write_pos_reg] <= q_item.data;
        rdata_reg <= ring_mem[read_pos_next];
    end

endmodule

// ===== rtl/line_framed_char_ring_buffer_top.sv =====
`timescale 1ns / 1ps
// line_framed_char_ring_buffer_top: top level of the line-framed character ring buffer.
// Depends on lfcrb_pkg, lfcrb_front, lfcrb_back.
//
// Input channel (in_valid/in_stall): command 0 pushes char_in into the ring,
// command 1 pops one newline-terminated line. A two-entry queue takes
// transactions while the execution side is busy; in_stall rises when it is full.
// Output channel (out_valid/out_stall): one transaction per popped byte, with
// last set on the newline that ends the line.
// Timing: a push is executed as the execution side takes it, so pushes sustain
// one per cycle while no pop is in progress. A pop takes the command, primes
// the registered ring read, then streams one byte per cycle unless out_stall
// holds it. The first byte passes the command queue, the take, B_PRIME and the
// output register. A pop with no stored line produces nothing.
// Stalls: out_stall holds the output register; the pop stream then pauses and
// the command queue fills until in_stall is raised.
// Reset: read/write indexes and the line count clear; ring contents are left
// as they are and are only read after being written.
module line_framed_char_ring_buffer_top
    import lfcrb_pkg::*;
#(
    parameter int unsigned DEPTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       command,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] char_out,
    output logic       last
);

    logic  q_valid;
    logic  q_take;
    item_t q_item;

    lfcrb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .char_in  (char_in),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_take   (q_take)
    );

    lfcrb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_take    (q_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_out  (char_out),
        .last      (last)
    );

endmodule

// ===== rtl/lfcrb_checker.sv =====
`timescale 1ns / 1ps
// lfcrb_checker: port-level assertions for line_framed_char_ring_buffer_top, with bind.
// Depends on lfcrb_pkg.
module lfcrb_checker
    import lfcrb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       command,
    input logic [7:0] char_in,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] char_out,
    input logic       last
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(command) && $stable(char_in))
        else $error("stalled input transaction changed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(char_out) && $stable(last))
        else $error("stalled output transaction changed");

    a_last_on_newline: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (char_out == NEWLINE_BYTE)))
        else $error("last does not match newline byte");

    a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid))
        else $error("input stall rose without a prior transaction");

endmodule

bind line_framed_char_ring_buffer_top lfcrb_checker u_lfcrb_checker (.*);

// ===== dv/tb_line_framed_char_ring_buffer_top.sv =====
`timescale 1ns / 1ps
// tb_line_framed_char_ring_buffer_top: self-checking testbench for the line-framed ring buffer.
// Depends on lfcrb_pkg and line_framed_char_ring_buffer_top; predicts popped lines per transaction.
module tb_line_framed_char_ring_buffer_top;
    import lfcrb_pkg::*;

    localparam int unsigned DEPTH          = 64;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          TAIL_CYCLES    = 16;
    localparam int          TARGET_ITEMS   = 500;
    localparam int          MAX_REPORTS    = 10;

    typedef struct {
        op_t        cmd;
        logic [7:0] ch;
        bit         drain;
        bit         hold;
    } stim_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } line_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       command = 1'b0;
    logic [7:0] char_in = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] char_out;
    logic       last;

    // predictor state
    logic [7:0]      ring_mem [DEPTH];
    logic [5:0]      wr_idx;
    logic [5:0]      rd_idx;
    logic [LC_W-1:0] line_cnt;

    line_byte_t popped_bytes [$];
    stim_t      stim_q [$];
    stim_t      cur;

    int  n_push = 0;
    int  n_pop = 0;
    int  n_bytes_out = 0;
    int  n_dropped = 0;
    int  n_empty_pops = 0;
    int  longest_line = 0;
    int  n_mismatch = 0;

    int  gap_left = 0;
    bit  drv_calm = 1'b0;
    int  wait_left = 0;
    bit  mon_calm = 1'b0;
    int  hold_seq = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  idle_cycles = 0;

    line_framed_char_ring_buffer_top #(.DEPTH(DEPTH)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .char_in   (char_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_out  (char_out),
        .last      (last)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [5:0] next_idx(input logic [5:0] idx);
        if (idx == DEPTH - 1)
            return '0;
        return idx + 6'd1;
    endfunction

    task automatic apply_command(input op_t cmd, input logic [7:0] ch);
        logic [7:0] b;
        logic       at_end;
        int         n;
        if (cmd == OP_PUSH)
        begin
            n_push++;
            if (line_cnt != '0 && wr_idx == rd_idx)
            begin
                n_dropped++;
                return;
            end
            ring_mem[wr_idx] = ch;
            wr_idx = next_idx(wr_idx);
            if (ch == NEWLINE_BYTE && line_cnt < LINE_COUNT_MAX)
                line_cnt++;
            return;
        end
        n_pop++;
        if (line_cnt == '0)
        begin
            n_empty_pops++;
            return;
        end
        n = 0;
        while (n < DEPTH)
        begin
            b = ring_mem[rd_idx];
            at_end = (b == NEWLINE_BYTE);
            rd_idx = next_idx(rd_idx);
            popped_bytes.push_back('{ch: b, last: at_end});
            n++;
            if (at_end)
                break;
        end
        if (n > longest_line)
            longest_line = n;
        line_cnt--;
    endtask

    task automatic add_item(input op_t cmd, input logic [7:0] ch,
                            input bit drain = 1'b0, input bit hold = 1'b0);
        stim_q.push_back('{cmd: cmd, ch: ch, drain: drain, hold: hold});
    endtask

    task automatic add_line(input int len);
        for (int i = 0; i < len; i++)
            add_item(OP_PUSH, 8'($urandom_range(0, 255)));
        add_item(OP_PUSH, NEWLINE_BYTE);
    endtask

    task automatic note_mismatch(input string what, input line_byte_t exp_b,
                                 input logic [7:0] act_ch, input logic act_last);
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
            $display("[%0t] %s: expected char_out=%02h last=%b, got char_out=%02h last=%b",
                     $realtime, what, exp_b.ch, exp_b.last, act_ch, act_last);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command  <= OP_PUSH;
            char_in  <= 8'h00;
            gap_left = 0;
            wr_idx   = '0;
            rd_idx   = '0;
            line_cnt = '0;
            for (int i = 0; i < DEPTH; i++)
                ring_mem[i] = 8'h00;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
            begin
                apply_command(cur.cmd, cur.ch);
                if ($urandom_range(0, 39) == 0)
                    drv_calm = !drv_calm;
                gap_left = drv_calm ? 0 : $urandom_range(0, 3);
            end
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (stim_q.size() > 0 && !(stim_q[0].drain && popped_bytes.size() != 0))
            begin
                cur = stim_q.pop_front();
                if (cur.hold)
                    hold_seq <= hold_seq + 1;
                in_valid <= 1'b1;
                command  <= cur.cmd;
                char_in  <= cur.ch;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        line_byte_t exp_b;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            wait_left = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                n_bytes_out++;
                if (popped_bytes.size() == 0)
                    note_mismatch("unexpected transaction", '{ch: 'x, last: 'x},
                                  char_out, last);
                else
                begin
                    exp_b = popped_bytes.pop_front();
                    if (char_out !== exp_b.ch || last !== exp_b.last)
                        note_mismatch("mismatch", exp_b, char_out, last);
                end
                if ($urandom_range(0, 39) == 0)
                    mon_calm = !mon_calm;
                wait_left = mon_calm ? 0 : $urandom_range(0, 3);
            end
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (wait_left > 0)
            begin
                wait_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout after %0d idle cycles", idle_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        bit pressure_done;
        int kind;
        int n;

        // directed: extremes, empty pops, near-newline bytes
        add_item(OP_POP, 8'h00);
        add_item(OP_PUSH, 8'h00);
        add_item(OP_PUSH, 8'hFF);
        add_item(OP_PUSH, NEWLINE_BYTE);
        add_item(OP_POP, 8'hFF);
        add_item(OP_PUSH, NEWLINE_BYTE);
        add_item(OP_POP, 8'h00);
        add_item(OP_PUSH, 8'h78);
        add_item(OP_POP, 8'h55);
        add_item(OP_PUSH, NEWLINE_BYTE);
        add_item(OP_POP, 8'hAA);
        add_item(OP_PUSH, 8'h09);
        add_item(OP_PUSH, 8'h0B);
        add_item(OP_PUSH, NEWLINE_BYTE);
        add_item(OP_PUSH, 8'h41);
        add_item(OP_PUSH, NEWLINE_BYTE);
        add_item(OP_POP, 8'h00);
        add_item(OP_POP, 8'h00);
        add_item(OP_POP, 8'h00);
        add_item(OP_PUSH, 8'h7F);
        add_item(OP_PUSH, 8'h80);
        add_item(OP_PUSH, NEWLINE_BYTE);
        add_item(OP_POP, 8'h0A);

        // receiver holds off while lines and pops keep coming
        add_item(OP_PUSH, 8'h61, 1'b1, 1'b1);
        for (int i = 0; i < 6; i++)
        begin
            add_line($urandom_range(1, 4));
            add_item(OP_POP, 8'($urandom_range(0, 255)));
        end
        add_item(OP_POP, 8'h00);

        pressure_done = 1'b0;
        while (stim_q.size() < TARGET_ITEMS)
        begin
            if (!pressure_done && stim_q.size() > TARGET_ITEMS / 2)
            begin
                pressure_done = 1'b1;
                add_item(OP_PUSH, 8'($urandom_range(0, 255)), 1'b1, 1'b1);
                for (int i = 0; i < 5; i++)
                begin
                    add_line($urandom_range(0, 8));
                    add_item(OP_POP, 8'($urandom_range(0, 255)));
                end
                add_item(OP_POP, 8'h00, 1'b1);
            end
            kind = $urandom_range(0, 99);
            if (kind < 50)
            begin
                add_line($urandom_range(0, 10));
                if ($urandom_range(0, 1))
                    add_item(OP_POP, 8'($urandom_range(0, 255)));
            end
            else if (kind < 58)
            begin
                add_line($urandom_range(50, 70));
                add_item(OP_POP, 8'($urandom_range(0, 255)));
            end
            else if (kind < 66)
            begin
                // fill the ring with short lines so later pushes are dropped
                n = 0;
                while (n < 70)
                begin
                    kind = $urandom_range(0, 6);
                    add_line(kind);
                    n += kind + 1;
                end
                n = $urandom_range(3, 12);
                for (int i = 0; i < n; i++)
                    add_item(OP_POP, 8'($urandom_range(0, 255)));
            end
            else if (kind < 84)
            begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    add_item(OP_POP, 8'($urandom_range(0, 255)));
            end
            else
            begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    add_item(op_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
        end
        for (int i = 0; i < 20; i++)
            add_item(OP_POP, 8'($urandom_range(0, 255)));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (stim_q.size() != 0 || in_valid)
            @(posedge clk);
        while (popped_bytes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (popped_bytes.size() != 0)
        begin
            n_mismatch += popped_bytes.size();
            $display("%0d expected bytes never arrived", popped_bytes.size());
        end
        $display("Summary: %0d pushes (%0d dropped on a full ring), %0d pops (%0d with no line)",
                 n_push, n_dropped, n_pop, n_empty_pops);
        $display("Summary: %0d bytes out, longest line %0d bytes, %0d mismatches",
                 n_bytes_out, longest_line, n_mismatch);
        if (n_mismatch == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
